// ===== rtl/led_animation_frame_decoder_unit_defines.svh =====
// assertion macros for the led animation frame decoder checker
// no dependencies; included by the checker file only
`ifndef LED_ANIMATION_FRAME_DECODER_UNIT_DEFINES_SVH
`define LED_ANIMATION_FRAME_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LAFD_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("lafd check failed");

// next-cycle implication, disabled in reset
`define LAFD_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("lafd check failed");

`endif

// ===== rtl/lafd_pkg.sv =====
// types, constants and sequencer program for the led animation frame decoder
// no dependencies; used by every module of the block but lafd_ram
`default_nettype none

package lafd_pkg;

  localparam int DISPLAY_WIDTH_DEF  = 48;
  localparam int DISPLAY_HEIGHT_DEF = 16;
  localparam int SMALL_START_ROW    = 8;
  localparam int DELAY_W            = 16;
  localparam int FCOUNT_W           = 7;
  localparam logic CFG_SMALL_RESET  = 1'b1;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       file_start;
  } in_item_t;

  typedef struct packed {
    logic               pixel_valid;
    logic [5:0]         pixel_x;
    logic [3:0]         pixel_y;
    logic               pixel_on;
    logic               frame_end;
    logic [DELAY_W-1:0] frame_delay;
    logic               animation_done;
    logic               big_type;
    logic               last;
  } out_item_t;

  typedef enum logic [1:0] {
    PH_HDR0,
    PH_HDR1,
    PH_HDR2,
    PH_DATA
  } phase_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISP,
    ST_CHK1,
    ST_CHK2,
    ST_HDR0,
    ST_HDR0_LD,
    ST_HDR1,
    ST_HDR2,
    ST_ZERO,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DIV_LD,
    ST_DATA_RD,
    ST_DATA_CMP,
    ST_DATA_TST,
    ST_PIX,
    ST_FEND_CHK,
    ST_MARK_CHK,
    ST_MARK,
    ST_FEND
  } step_t;

  typedef enum logic [3:0] {
    A_NONE,
    A_LD_H0,
    A_LD_H1,
    A_LD_H2,
    A_EMIT_ZERO,
    A_DIV_GO,
    A_LD_DELAY,
    A_RD,
    A_CMP,
    A_EMIT_PIX,
    A_EMIT_MARK,
    A_FEND
  } act_t;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_NOACC,
    C_HDR0,
    C_PH1,
    C_PH2,
    C_NOSTART,
    C_NZCOUNT,
    C_DIVBUSY,
    C_DIFFZ,
    C_MORE,
    C_NOFLAST
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t jmp;
    step_t seq;
  } ucode_t;

  function automatic ucode_t ucode_rom(input step_t pc);
    ucode_t w;
    w = '{act: A_NONE, cond: C_ALWAYS, jmp: ST_IDLE, seq: ST_IDLE};
    case (pc)
      ST_IDLE:     w = '{act: A_NONE,      cond: C_NOACC,   jmp: ST_IDLE,     seq: ST_DISP};
      ST_DISP:     w = '{act: A_NONE,      cond: C_HDR0,    jmp: ST_HDR0,     seq: ST_CHK1};
      ST_CHK1:     w = '{act: A_NONE,      cond: C_PH1,     jmp: ST_HDR1,     seq: ST_CHK2};
      ST_CHK2:     w = '{act: A_NONE,      cond: C_PH2,     jmp: ST_HDR2,     seq: ST_DATA_RD};
      ST_HDR0:     w = '{act: A_NONE,      cond: C_NOSTART, jmp: ST_IDLE,     seq: ST_HDR0_LD};
      ST_HDR0_LD:  w = '{act: A_LD_H0,     cond: C_ALWAYS,  jmp: ST_IDLE,     seq: ST_IDLE};
      ST_HDR1:     w = '{act: A_LD_H1,     cond: C_ALWAYS,  jmp: ST_IDLE,     seq: ST_IDLE};
      ST_HDR2:     w = '{act: A_LD_H2,     cond: C_NZCOUNT, jmp: ST_DIV_GO,   seq: ST_ZERO};
      ST_ZERO:     w = '{act: A_EMIT_ZERO, cond: C_ALWAYS,  jmp: ST_IDLE,     seq: ST_IDLE};
      ST_DIV_GO:   w = '{act: A_DIV_GO,    cond: C_ALWAYS,  jmp: ST_DIV_WAIT, seq: ST_DIV_WAIT};
      ST_DIV_WAIT: w = '{act: A_NONE,      cond: C_DIVBUSY, jmp: ST_DIV_WAIT, seq: ST_DIV_LD};
      ST_DIV_LD:   w = '{act: A_LD_DELAY,  cond: C_ALWAYS,  jmp: ST_IDLE,     seq: ST_IDLE};
      ST_DATA_RD:  w = '{act: A_RD,        cond: C_ALWAYS,  jmp: ST_DATA_CMP, seq: ST_DATA_CMP};
      ST_DATA_CMP: w = '{act: A_CMP,       cond: C_ALWAYS,  jmp: ST_DATA_TST, seq: ST_DATA_TST};
      ST_DATA_TST: w = '{act: A_NONE,      cond: C_DIFFZ,   jmp: ST_MARK_CHK, seq: ST_PIX};
      ST_PIX:      w = '{act: A_EMIT_PIX,  cond: C_MORE,    jmp: ST_PIX,      seq: ST_FEND_CHK};
      ST_FEND_CHK: w = '{act: A_NONE,      cond: C_NOFLAST, jmp: ST_IDLE,     seq: ST_FEND};
      ST_MARK_CHK: w = '{act: A_NONE,      cond: C_NOFLAST, jmp: ST_IDLE,     seq: ST_MARK};
      ST_MARK:     w = '{act: A_EMIT_MARK, cond: C_ALWAYS,  jmp: ST_FEND,     seq: ST_FEND};
      ST_FEND:     w = '{act: A_FEND,      cond: C_ALWAYS,  jmp: ST_IDLE,     seq: ST_IDLE};
      default:     w = '{act: A_NONE,      cond: C_ALWAYS,  jmp: ST_IDLE,     seq: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lafd_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module lafd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 96
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/lafd_div.sv =====
// iterative restoring divider, one quotient bit per cycle
// depends on lafd_pkg for the delay and frame count widths
`default_nettype none

module lafd_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [lafd_pkg::DELAY_W-1:0]  dividend,
  input  wire logic [lafd_pkg::FCOUNT_W-1:0] divisor,
  output logic                               busy,
  output logic      [lafd_pkg::DELAY_W-1:0]  quotient
);

  localparam int DW = lafd_pkg::DELAY_W;
  localparam int VW = lafd_pkg::FCOUNT_W;
  localparam int NW = $clog2(DW);

  logic          busy_r, busy_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [VW-1:0] dvs_r, dvs_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW:0]   shifted;
  logic [VW:0]   trial;
  logic          ge;

  assign shifted = {rem_r, quo_r[DW-1]};
  assign ge      = shifted >= {1'b0, dvs_r};
  assign trial   = shifted - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = NW'(DW - 1);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? trial[VW-1:0] : shifted[VW-1:0];
      quo_nxt = {quo_r[DW-2:0], ge};
      cnt_nxt = cnt_r - NW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ===== rtl/led_animation_frame_decoder_unit.sv =====
// top level of the led animation frame decoder: microcoded sequencer and datapath
// depends on lafd_pkg, lafd_ram (frame store) and lafd_div (frame delay)
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | lafd_pkg::in_item_t
//   out_    | output    | out_valid/out_stall | lafd_pkg::out_item_t
//   cfg_    | input     | cfg_we              | cfg_wdata (small type code)
//
// one item at a time; a zero-frame third header byte emits a zero-frame item, any other
// third header byte waits for the 16-step frame delay divider
// a data byte: frame store read, compare, one pixel item per changed bit, a frame-end step
// at the last byte of a frame, and a marker item instead if no bit changed there
// after reset a clear pass writes the frame store, DISPLAY_HEIGHT*DISPLAY_WIDTH/8 bytes,
// with in_stall high; out_stall holds the sequencer on its emit step; one output register
`default_nettype none

module led_animation_frame_decoder_unit #(
  parameter int DISPLAY_WIDTH  = lafd_pkg::DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = lafd_pkg::DISPLAY_HEIGHT_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire lafd_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output lafd_pkg::out_item_t      out_item,
  input  wire logic                cfg_we,
  input  wire logic                cfg_wdata
);

  localparam int COLS     = DISPLAY_WIDTH / 8;
  localparam int DEPTH    = DISPLAY_HEIGHT * COLS;
  localparam int AW       = $clog2(DEPTH);
  localparam int RW       = $clog2(DISPLAY_HEIGHT + 1);
  localparam int CW       = $clog2(COLS + 1);
  localparam bit SMALL_OK = lafd_pkg::SMALL_START_ROW < DISPLAY_HEIGHT;
  localparam int DW       = lafd_pkg::DELAY_W;
  localparam int VW       = lafd_pkg::FCOUNT_W;

  lafd_pkg::step_t  pc_r, pc_nxt;
  lafd_pkg::phase_t phase_r, phase_nxt;
  lafd_pkg::ucode_t uc;

  logic          cfg_small_r, cfg_small_nxt;
  logic          clr_busy_r, clr_busy_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;

  logic [7:0]    byte_r, byte_nxt;
  logic          start_r, start_nxt;
  logic          type_r, type_nxt;
  logic [VW-1:0] ftot_r, ftot_nxt;
  logic [DW-1:0] ttime_r, ttime_nxt;
  logic [DW-1:0] delay_r, delay_nxt;
  logic [VW-1:0] fshown_r, fshown_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] cur_row_r, cur_row_nxt;
  logic [CW-1:0] cur_col_r, cur_col_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [7:0]    diff_r, diff_nxt;
  logic          flast_r, flast_nxt;
  logic          done_r, done_nxt;

  logic                out_valid_r, out_valid_nxt;
  lafd_pkg::out_item_t out_data_r, out_data_nxt;

  logic          in_acc;
  logic          out_free;
  logic          is_emit;
  logic          hold;
  logic          cond_hit;
  logic          small_sel;
  logic [RW-1:0] start_row;
  logic [RW-1:0] r_eff;
  logic [CW-1:0] c_eff;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] c_inc;
  logic [RW-1:0] r_inc;
  logic [VW-1:0] fshown_inc;
  logic [2:0]    low_k;
  logic [7:0]    diff_clr;
  logic          more;
  logic [CW+2:0] x_full;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;
  logic          div_start;
  logic          div_busy;
  logic [DW-1:0] div_quo;

  assign uc        = lafd_pkg::ucode_rom(pc_r);
  assign in_stall  = (pc_r != lafd_pkg::ST_IDLE) || clr_busy_r;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign is_emit   = uc.act inside {lafd_pkg::A_EMIT_ZERO, lafd_pkg::A_EMIT_PIX,
                                    lafd_pkg::A_EMIT_MARK};
  assign hold      = is_emit && !out_free;
  assign small_sel = type_r == cfg_small_r;
  assign start_row = (small_sel && SMALL_OK) ? RW'(lafd_pkg::SMALL_START_ROW) : '0;
  assign r_eff     = (row_r >= RW'(DISPLAY_HEIGHT)) ? '0 : row_r;
  assign c_eff     = (col_r >= CW'(COLS)) ? '0 : col_r;
  assign rd_addr   = AW'(r_eff) * AW'(COLS) + AW'(c_eff);
  assign c_inc     = cur_col_r + CW'(1);
  assign r_inc     = cur_row_r + RW'(1);
  assign fshown_inc = fshown_r + VW'(1);
  assign diff_clr  = diff_r & (diff_r - 8'd1);
  assign more      = diff_clr != 8'd0;
  assign x_full    = {cur_col_r, low_k};

  always_comb begin
    low_k = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (diff_r[i]) begin
        low_k = 3'(i);
      end
    end
  end

  always_comb begin
    case (uc.cond)
      lafd_pkg::C_ALWAYS:  cond_hit = 1'b1;
      lafd_pkg::C_NOACC:   cond_hit = !in_acc;
      lafd_pkg::C_HDR0:    cond_hit = start_r || (phase_r == lafd_pkg::PH_HDR0);
      lafd_pkg::C_PH1:     cond_hit = phase_r == lafd_pkg::PH_HDR1;
      lafd_pkg::C_PH2:     cond_hit = phase_r == lafd_pkg::PH_HDR2;
      lafd_pkg::C_NOSTART: cond_hit = !start_r;
      lafd_pkg::C_NZCOUNT: cond_hit = ftot_r != '0;
      lafd_pkg::C_DIVBUSY: cond_hit = div_busy;
      lafd_pkg::C_DIFFZ:   cond_hit = diff_r == 8'd0;
      lafd_pkg::C_MORE:    cond_hit = more;
      lafd_pkg::C_NOFLAST: cond_hit = !flast_r;
      default:             cond_hit = 1'b1;
    endcase
  end

  always_comb begin
    pc_nxt        = hold ? pc_r : (cond_hit ? uc.jmp : uc.seq);
    phase_nxt     = phase_r;
    cfg_small_nxt = cfg_we ? cfg_wdata : cfg_small_r;
    clr_busy_nxt  = clr_busy_r;
    clr_addr_nxt  = clr_addr_r;
    byte_nxt      = byte_r;
    start_nxt     = start_r;
    type_nxt      = type_r;
    ftot_nxt      = ftot_r;
    ttime_nxt     = ttime_r;
    delay_nxt     = delay_r;
    fshown_nxt    = fshown_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    addr_nxt      = addr_r;
    diff_nxt      = diff_r;
    flast_nxt     = flast_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;

    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end

    if (in_acc) begin
      byte_nxt  = in_item.file_byte;
      start_nxt = in_item.file_start;
    end

    if (!hold) begin
      case (uc.act)
        lafd_pkg::A_LD_H0: begin
          type_nxt  = byte_r[0];
          ftot_nxt  = byte_r[7:1];
          phase_nxt = lafd_pkg::PH_HDR1;
        end
        lafd_pkg::A_LD_H1: begin
          ttime_nxt = {byte_r, 8'h00};
          phase_nxt = lafd_pkg::PH_HDR2;
        end
        lafd_pkg::A_LD_H2: begin
          ttime_nxt  = {ttime_r[DW-1:8], byte_r};
          fshown_nxt = '0;
          col_nxt    = '0;
          row_nxt    = start_row;
        end
        lafd_pkg::A_EMIT_ZERO: begin
          delay_nxt     = '0;
          phase_nxt     = lafd_pkg::PH_HDR0;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.animation_done = 1'b1;
          out_data_nxt.big_type       = !small_sel;
          out_data_nxt.last           = 1'b1;
        end
        lafd_pkg::A_DIV_GO: begin
          div_start = 1'b1;
        end
        lafd_pkg::A_LD_DELAY: begin
          delay_nxt = div_quo;
          phase_nxt = lafd_pkg::PH_DATA;
        end
        lafd_pkg::A_RD: begin
          cur_row_nxt = r_eff;
          cur_col_nxt = c_eff;
          addr_nxt    = rd_addr;
        end
        lafd_pkg::A_CMP: begin
          diff_nxt  = ram_rdata ^ byte_r;
          flast_nxt = 1'b0;
          if (c_inc >= CW'(COLS)) begin
            col_nxt = '0;
            row_nxt = r_inc;
            if (r_inc >= RW'(DISPLAY_HEIGHT)) begin
              flast_nxt  = 1'b1;
              fshown_nxt = fshown_inc;
              done_nxt   = fshown_inc == ftot_r;
            end
          end else begin
            col_nxt = c_inc;
            row_nxt = cur_row_r;
          end
        end
        lafd_pkg::A_EMIT_PIX: begin
          diff_nxt      = diff_clr;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.pixel_valid = 1'b1;
          out_data_nxt.pixel_x     = 6'(x_full);
          out_data_nxt.pixel_y     = 4'(cur_row_r);
          out_data_nxt.pixel_on    = byte_r[low_k];
          out_data_nxt.last        = !more;
          if (!more && flast_r) begin
            out_data_nxt.frame_end      = 1'b1;
            out_data_nxt.frame_delay    = delay_r;
            out_data_nxt.animation_done = done_r;
            out_data_nxt.big_type       = !small_sel;
          end
        end
        lafd_pkg::A_EMIT_MARK: begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.frame_end      = 1'b1;
          out_data_nxt.frame_delay    = delay_r;
          out_data_nxt.animation_done = done_r;
          out_data_nxt.big_type       = !small_sel;
          out_data_nxt.last           = 1'b1;
        end
        lafd_pkg::A_FEND: begin
          if (done_r) begin
            phase_nxt = lafd_pkg::PH_HDR0;
          end else begin
            row_nxt = start_row;
            col_nxt = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= lafd_pkg::ST_IDLE;
      phase_r     <= lafd_pkg::PH_HDR0;
      cfg_small_r <= lafd_pkg::CFG_SMALL_RESET;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      type_r      <= 1'b0;
      ftot_r      <= '0;
      ttime_r     <= '0;
      delay_r     <= '0;
      fshown_r    <= '0;
      row_r       <= '0;
      col_r       <= '0;
      flast_r     <= 1'b0;
      done_r      <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      phase_r     <= phase_nxt;
      cfg_small_r <= cfg_small_nxt;
      clr_busy_r  <= clr_busy_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      type_r      <= type_nxt;
      ftot_r      <= ftot_nxt;
      ttime_r     <= ttime_nxt;
      delay_r     <= delay_nxt;
      fshown_r    <= fshown_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      flast_r     <= flast_nxt;
      done_r      <= done_nxt;
    end
    byte_r     <= byte_nxt;
    start_r    <= start_nxt;
    cur_row_r  <= cur_row_nxt;
    cur_col_r  <= cur_col_nxt;
    addr_r     <= addr_nxt;
    diff_r     <= diff_nxt;
    out_data_r <= out_data_nxt;
  end

  // frame store write: clear pass first, then the new byte on compare
  assign ram_we    = clr_busy_r || (uc.act == lafd_pkg::A_CMP);
  assign ram_waddr = clr_busy_r ? clr_addr_r : addr_r;
  assign ram_wdata = clr_busy_r ? 8'h00 : byte_r;

  lafd_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  lafd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ttime_r),
    .divisor  (ftot_r),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/lafd_chk.sv =====
// port-level checker for the led animation frame decoder, bound to the top level
// depends on lafd_pkg and the assertion macros header
`default_nettype none
`include "led_animation_frame_decoder_unit_defines.svh"

module lafd_chk (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire lafd_pkg::out_item_t out_item
);

  // stalled item holds
  `LAFD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_item))

  // an item without a pixel is a marker or a zero-frame item, always the last one
  `LAFD_ASSERT_IMP(a_nopix_last, clk, rst_n, out_valid && !out_item.pixel_valid, out_item.last && (out_item.pixel_x == 6'd0) && (out_item.pixel_y == 4'd0) && !out_item.pixel_on)

  // delay only rides on a frame end
  `LAFD_ASSERT_IMP(a_delay_fend, clk, rst_n, out_valid && !out_item.frame_end, out_item.frame_delay == 16'd0)

  // frame end closes the byte
  `LAFD_ASSERT_IMP(a_fend_last, clk, rst_n, out_valid && out_item.frame_end, out_item.last)

  // a pixel item reports done only together with frame end
  `LAFD_ASSERT_IMP(a_pix_done, clk, rst_n, out_valid && out_item.pixel_valid, !out_item.animation_done || out_item.frame_end)

endmodule

bind led_animation_frame_decoder_unit lafd_chk u_lafd_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// self-checking testbench for led_animation_frame_decoder_unit: feeds animation files
// byte by byte, predicts pixel plots and frame-end markers, compares every result item
// depends on lafd_pkg and the rtl top level only
`default_nettype none

module tb;

  localparam int ROWS         = lafd_pkg::DISPLAY_HEIGHT_DEF;
  localparam int ROW_BYTES    = lafd_pkg::DISPLAY_WIDTH_DEF / 8;
  localparam int PHASE_ITEMS  = 129;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int WATCH_LIMIT  = 4000;
  localparam int MAX_PRINTS   = 40;

  typedef enum int {
    FILL_RANDOM,
    FILL_SAME,
    FILL_SPARSE,
    FILL_SOLID
  } fill_t;

  class frame_scoreboard;
    lafd_pkg::out_item_t pending_results[$];
    int errors;
    int checked;
    logic small_code;
    lafd_pkg::phase_t phase;
    logic type_bit;
    logic [6:0] frame_count;
    logic [6:0] frames_done;
    logic [15:0] total_ms;
    logic [15:0] delay_ms;
    int row;
    int col;
    logic [lafd_pkg::DISPLAY_WIDTH_DEF-1:0] pixels [ROWS];

    function new();
      errors = 0;
      checked = 0;
      small_code = lafd_pkg::CFG_SMALL_RESET;
      phase = lafd_pkg::PH_HDR0;
      type_bit = 1'b0;
      frame_count = '0;
      frames_done = '0;
      total_ms = '0;
      delay_ms = '0;
      row = 0;
      col = 0;
      for (int i = 0; i < ROWS; i++) pixels[i] = '0;
    endfunction

    function void set_small(logic v);
      small_code = v;
    endfunction

    function int first_row();
      if (type_bit == small_code && lafd_pkg::SMALL_START_ROW < ROWS)
        return lafd_pkg::SMALL_START_ROW;
      return 0;
    endfunction

    function logic is_big();
      return type_bit != small_code;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function logic ignores(logic s);
      return !s && phase == lafd_pkg::PH_HDR0;
    endfunction

    function logic in_data();
      return phase == lafd_pkg::PH_DATA;
    endfunction

    function int frame_bytes_left();
      return (ROWS - row) * ROW_BYTES - col;
    endfunction

    function logic [7:0] stored_byte();
      int r;
      int c;
      r = (row >= ROWS) ? 0 : row;
      c = (col >= ROW_BYTES) ? 0 : col;
      return pixels[r][c*8 +: 8];
    endfunction

    function void decode_byte(lafd_pkg::in_item_t it);
      lafd_pkg::out_item_t res [8];
      lafd_pkg::out_item_t z;
      logic [7:0] b;
      logic [7:0] old;
      int n;
      int r;
      int c;
      logic done;
      b = it.file_byte;
      n = 0;
      z = '0;
      if (it.file_start) phase = lafd_pkg::PH_HDR0;
      case (phase)
        lafd_pkg::PH_HDR0: begin
          if (it.file_start) begin
            type_bit = b[0];
            frame_count = b[7:1];
            phase = lafd_pkg::PH_HDR1;
          end
        end
        lafd_pkg::PH_HDR1: begin
          total_ms = {b, 8'h00};
          phase = lafd_pkg::PH_HDR2;
        end
        lafd_pkg::PH_HDR2: begin
          total_ms[7:0] = b;
          frames_done = '0;
          col = 0;
          row = first_row();
          if (frame_count == 0) begin
            delay_ms = '0;
            phase = lafd_pkg::PH_HDR0;
            z.animation_done = 1'b1;
            z.big_type = is_big();
            z.last = 1'b1;
            pending_results.push_back(z);
          end else begin
            delay_ms = 16'(total_ms / {9'b0, frame_count});
            phase = lafd_pkg::PH_DATA;
          end
        end
        default: begin
          r = (row >= ROWS) ? 0 : row;
          c = (col >= ROW_BYTES) ? 0 : col;
          old = pixels[r][c*8 +: 8];
          for (int k = 0; k < 8; k++) begin
            if (b[k] != old[k]) begin
              res[n] = '0;
              res[n].pixel_valid = 1'b1;
              res[n].pixel_x = 6'(c * 8 + k);
              res[n].pixel_y = 4'(r);
              res[n].pixel_on = b[k];
              n++;
            end
          end
          pixels[r][c*8 +: 8] = b;
          c++;
          if (c >= ROW_BYTES) begin
            c = 0;
            r++;
          end
          row = r;
          col = c;
          if (r >= ROWS) begin
            frames_done = frames_done + 7'd1;
            done = (frames_done == frame_count);
            if (n == 0) begin
              res[0] = '0;
              n = 1;
            end
            res[n-1].frame_end = 1'b1;
            res[n-1].frame_delay = delay_ms;
            res[n-1].animation_done = done;
            res[n-1].big_type = is_big();
            if (done) begin
              phase = lafd_pkg::PH_HDR0;
            end else begin
              row = first_row();
              col = 0;
            end
          end
          if (n > 0) res[n-1].last = 1'b1;
          for (int k = 0; k < n; k++) pending_results.push_back(res[k]);
        end
      endcase
    endfunction

    task report_mismatch(string msg);
      if (errors < MAX_PRINTS) $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_result(lafd_pkg::out_item_t got);
      lafd_pkg::out_item_t want;
      string bad;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: %h", got));
        return;
      end
      want = pending_results.pop_front();
      bad = "";
      if (got.pixel_valid !== want.pixel_valid) bad = {bad, " pixel_valid"};
      if (got.pixel_x !== want.pixel_x) bad = {bad, " pixel_x"};
      if (got.pixel_y !== want.pixel_y) bad = {bad, " pixel_y"};
      if (got.pixel_on !== want.pixel_on) bad = {bad, " pixel_on"};
      if (got.frame_end !== want.frame_end) bad = {bad, " frame_end"};
      if (got.frame_delay !== want.frame_delay) bad = {bad, " frame_delay"};
      if (got.animation_done !== want.animation_done) bad = {bad, " animation_done"};
      if (got.big_type !== want.big_type) bad = {bad, " big_type"};
      if (got.last !== want.last) bad = {bad, " last"};
      if (bad != "")
        report_mismatch($sformatf("result %0d wrong:%s got %h want %h", checked, bad, got, want));
      checked++;
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  lafd_pkg::in_item_t in_item;
  logic out_valid;
  logic out_stall;
  lafd_pkg::out_item_t out_item;
  logic cfg_we;
  logic cfg_wdata;
  logic hold_go = 1'b0;

  int snd_idle = 20;
  int rcv_idle = 87;
  int items_sent = 0;
  int item_goal = 0;

  frame_scoreboard sb = new();

  led_animation_frame_decoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    int hold_left;
    logic held;
    hold_left = 0;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !held) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rcv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  initial begin
    int quiet;
    quiet = 0;
    wait (rst_n === 1'b1);
    while (quiet < WATCH_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_item(input logic [7:0] b, input logic s);
    lafd_pkg::in_item_t it;
    it = '{file_byte: b, file_start: s};
    if ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!sb.ignores(s)) items_sent++;
    sb.decode_byte(it);
  endtask

  task automatic write_small(input logic v);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_small(v);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_data(fill_t mode);
    logic [7:0] cur;
    cur = sb.stored_byte();
    case (mode)
      FILL_RANDOM: return 8'($urandom());
      FILL_SAME:   return cur;
      FILL_SPARSE: return $urandom_range(1) ? cur : cur ^ (8'h01 << $urandom_range(7));
      default:     return $urandom_range(1) ? 8'h00 : 8'hFF;
    endcase
  endfunction

  function automatic fill_t pick_fill();
    int p;
    p = $urandom_range(99);
    if (p < 40) return FILL_RANDOM;
    if (p < 60) return FILL_SAME;
    if (p < 85) return FILL_SPARSE;
    return FILL_SOLID;
  endfunction

  task automatic send_header(input logic tbit, input logic [6:0] cnt, input logic [15:0] ms,
                             input int nbytes);
    if (nbytes > 0) send_item({cnt, tbit}, 1'b1);
    if (nbytes > 1) send_item(ms[15:8], 1'b0);
    if (nbytes > 2) send_item(ms[7:0], 1'b0);
  endtask

  task automatic send_random_file();
    int pick;
    int nbytes;
    int frames;
    logic tbit;
    logic [6:0] cnt;
    logic [15:0] ms;
    fill_t mode;
    pick = $urandom_range(99);
    tbit = 1'($urandom_range(1));
    case ($urandom_range(9))
      0:       ms = 16'hFFFF;
      1:       ms = 16'h0000;
      default: ms = 16'($urandom());
    endcase
    if (pick < 8) begin
      repeat ($urandom_range(1, 3)) send_item(8'($urandom()), 1'b0);
    end else if (pick < 18) begin
      send_header(tbit, 7'd0, ms, 3);
    end else if (pick < 34) begin
      cnt = 7'($urandom_range(127));
      nbytes = $urandom_range(1, 4);
      send_header(tbit, cnt, ms, nbytes);
      if (nbytes > 3 && sb.in_data()) begin
        mode = pick_fill();
        repeat ($urandom_range(1, 30)) send_item(pick_data(mode), 1'b0);
      end
    end else begin
      frames = ($urandom_range(9) < 6) ? 1 : $urandom_range(2, 3);
      send_header(tbit, 7'(frames), ms, 3);
      for (int f = 0; f < frames && items_sent < item_goal; f++) begin
        mode = pick_fill();
        nbytes = sb.frame_bytes_left();
        for (int i = 0; i < nbytes && items_sent < item_goal; i++)
          send_item(pick_data(mode), 1'b0);
      end
    end
  endtask

  task automatic run_phase(input int snd, input int rcv, input logic v, input logic hold);
    write_small(v);
    snd_idle = snd;
    rcv_idle = rcv;
    if (hold) hold_go <= 1'b1;
    item_goal = items_sent + PHASE_ITEMS;
    while (items_sent < item_goal) send_random_file();
  endtask

  initial begin
    in_valid <= 1'b0;
    in_item <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= 1'b0;
    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    write_small(1'b0);
    // bytes outside a file are dropped
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    // zero-frame headers of both types
    send_header(1'b0, 7'd0, 16'hFFFF, 3);
    send_header(1'b1, 7'd0, 16'h0000, 3);
    // restart inside the header
    send_header(1'b0, 7'd127, 16'h1200, 2);
    // one frame, longest total time, then restart inside the data
    send_header(1'b1, 7'd1, 16'hFFFF, 3);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hA5, 1'b0);
    send_item(8'h5A, 1'b0);
    send_header(1'b1, 7'd127, 16'hFFFF, 3);
    send_item(8'h80, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'hFF, 1'b0);

    run_phase(20, 87, 1'b1, 1'b0);
    run_phase(87, 20, 1'b0, 1'b0);
    run_phase(0, 0, 1'b1, 1'b1);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
